[rtl/vfc_pkg.sv]
package vfc_pkg;

    // geometry of the vowel path
    localparam int unsigned SLOT_COUNT   = 3;
    localparam int unsigned ANCHOR_COUNT = 5;

    // knob and frequency constants
    localparam logic [11:0] KNOB_FULL  = 12'd4095;
    localparam logic [12:0] POS_ONE    = 13'd4096;
    localparam logic [12:0] SHIFT_BASE = 13'd2048;
    localparam logic [14:0] HZ_MIN     = 15'd40;
    localparam logic [14:0] HZ_MAX     = 15'd6000;

    // last slot index
    localparam logic [1:0] SLOT_LAST = 2'd2;

    // decoded frame word, one per accepted input word
    typedef struct packed {
        logic [1:0]  seg0;
        logic [12:0] wt0;
        logic [1:0]  seg1;
        logic [12:0] wt1;
        logic [12:0] shift;
        logic        alt;
        logic [31:0] carrier;
    } t_frame;

    // anchor frequencies: [table][anchor][slot]
    localparam logic [12:0] T_HZ [0:1][0:4][0:2] = '{
        '{ '{13'd609,  13'd1000, 13'd2450},
           '{13'd400,  13'd1700, 13'd2300},
           '{13'd238,  13'd1741, 13'd2450},
           '{13'd325,  13'd700,  13'd2550},
           '{13'd415,  13'd1400, 13'd2200} },
        '{ '{13'd1000, 13'd2450, 13'd3300},
           '{13'd1700, 13'd2300, 13'd3500},
           '{13'd1741, 13'd2450, 13'd3300},
           '{13'd700,  13'd2550, 13'd3400},
           '{13'd1400, 13'd2200, 13'd3300} }
    };

    // anchor gains in Q12: [table][anchor][slot]
    localparam logic [12:0] T_GAIN [0:1][0:4][0:2] = '{
        '{ '{13'd4096, 13'd2052, 13'd1028},
           '{13'd4096, 13'd1454, 13'd1630},
           '{13'd4096, 13'd410,  13'd648},
           '{13'd4096, 13'd1028, 13'd205},
           '{13'd4096, 13'd1028, 13'd648} },
        '{ '{13'd4096, 13'd2052, 13'd1028},
           '{13'd4096, 13'd1454, 13'd1028},
           '{13'd4096, 13'd410,  13'd410},
           '{13'd4096, 13'd1028, 13'd205},
           '{13'd4096, 13'd1028, 13'd410} }
    };

endpackage

[rtl/vfc_front.sv]
module vfc_front
    import vfc_pkg::*;
(
    input  logic [11:0] i_knob_x,
    input  logic [11:0] i_knob_y,
    input  logic        i_alt_mode,
    input  logic [31:0] i_pitch_increment,
    output t_frame      o_frame
);

    logic [12:0] pos0;
    logic [12:0] pos1;

    // full scale knob maps to one, channel 1 walks the path backward
    assign pos0 = (i_knob_x == KNOB_FULL) ? POS_ONE : {1'b0, i_knob_x};
    assign pos1 = POS_ONE - pos0;

    // segment and weight per channel, end of path pinned to the last anchor
    always_comb begin
        if (pos0[12]) begin
            o_frame.seg0 = 2'd3;
            o_frame.wt0  = POS_ONE;
        end else begin
            o_frame.seg0 = pos0[11:10];
            o_frame.wt0  = {1'b0, pos0[9:0], 2'b00};
        end
        if (pos1[12]) begin
            o_frame.seg1 = 2'd3;
            o_frame.wt1  = POS_ONE;
        end else begin
            o_frame.seg1 = pos1[11:10];
            o_frame.wt1  = {1'b0, pos1[9:0], 2'b00};
        end
    end

    // formant shift factor and pass-through fields
    assign o_frame.shift   = SHIFT_BASE + {1'b0, i_knob_y};
    assign o_frame.alt     = i_alt_mode;
    assign o_frame.carrier = i_pitch_increment;

endmodule

[rtl/vfc_queue.sv]
module vfc_queue
    import vfc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_push_word,
    input  logic   i_pop,
    output t_frame o_head,
    output logic   o_empty,
    output logic   o_full
);

    t_frame     r_mem [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_word;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

[rtl/vfc_back.sv]
module vfc_back
    import vfc_pkg::*;
#(
    parameter int unsigned SAMPLE_RATE_HZ = 48000
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_frame      i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_strobe,
    output logic        o_channel,
    output logic [1:0]  o_formant_slot,
    output logic [31:0] o_carrier_increment,
    output logic [29:0] o_formant_increment,
    output logic [12:0] o_formant_amplitude,
    output logic        o_last_result
);

    // hz * RECIP >> 31 equals floor(hz * 2^32 / rate) while hz * rate < 2^31
    localparam logic [63:0] RECIP =
        ((64'd1 << 63) + 64'(SAMPLE_RATE_HZ) - 64'd1) / 64'(SAMPLE_RATE_HZ);

    typedef struct packed {
        logic        ch;
        logic [1:0]  slot;
        logic        last;
        logic [31:0] carrier;
    } t_tag;

    // sequencer
    logic        r_ch;
    logic [1:0]  r_slot;
    logic        issue;
    logic        issue_last;

    // stage 1
    logic               r_s1_valid;
    t_tag               r_s1_tag;
    logic [12:0]        r_s1_hz_a;
    logic [12:0]        r_s1_gn_a;
    logic signed [27:0] r_s1_hz_prod;
    logic signed [27:0] r_s1_gn_prod;
    logic [12:0]        r_s1_shift;

    // stage 2
    logic               r_s2_valid;
    t_tag               r_s2_tag;
    logic [25:0]        r_s2_hzs;
    logic [12:0]        r_s2_gain;

    // stage 3
    logic               r_s3_valid;
    t_tag               r_s3_tag;
    logic [12:0]        r_s3_hz;
    logic [12:0]        r_s3_gain;

    // stage 4
    logic               r_s4_valid;
    t_tag               r_s4_tag;
    logic [44:0]        r_s4_plo;
    logic [44:0]        r_s4_phi;
    logic [12:0]        r_s4_gain;

    // output register
    logic               r_o_valid;
    t_tag               r_o_tag;
    logic [29:0]        r_o_inc;
    logic [12:0]        r_o_gain;

    // one result per cycle while a frame waits, pop with the sixth
    assign issue      = !i_empty;
    assign issue_last = r_ch && (r_slot == SLOT_LAST);
    assign o_pop      = issue && issue_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch   <= 1'b0;
            r_slot <= 2'd0;
        end else if (issue) begin
            if (r_slot == SLOT_LAST) begin
                r_slot <= 2'd0;
                r_ch   <= ~r_ch;
            end else begin
                r_slot <= r_slot + 2'd1;
            end
        end
    end

    // stage 1: anchor lookup and weighted difference
    logic [1:0]         seg;
    logic [2:0]         seg_next;
    logic [12:0]        wt;
    logic [12:0]        hz_a;
    logic [12:0]        hz_b;
    logic [12:0]        gn_a;
    logic [12:0]        gn_b;
    logic signed [13:0] hz_d;
    logic signed [13:0] gn_d;
    logic signed [13:0] wt_s;

    always_comb begin
        seg      = r_ch ? i_head.seg1 : i_head.seg0;
        wt       = r_ch ? i_head.wt1 : i_head.wt0;
        seg_next = {1'b0, seg} + 3'd1;
        hz_a     = T_HZ[i_head.alt][{1'b0, seg}][r_slot];
        hz_b     = T_HZ[i_head.alt][seg_next][r_slot];
        gn_a     = T_GAIN[i_head.alt][{1'b0, seg}][r_slot];
        gn_b     = T_GAIN[i_head.alt][seg_next][r_slot];
        hz_d     = $signed({1'b0, hz_b}) - $signed({1'b0, hz_a});
        gn_d     = $signed({1'b0, gn_b}) - $signed({1'b0, gn_a});
        wt_s     = $signed({1'b0, wt});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= issue;
        end
        r_s1_tag.ch      <= r_ch;
        r_s1_tag.slot    <= r_slot;
        r_s1_tag.last    <= issue_last;
        r_s1_tag.carrier <= i_head.carrier;
        r_s1_hz_a        <= hz_a;
        r_s1_gn_a        <= gn_a;
        r_s1_hz_prod     <= hz_d * wt_s;
        r_s1_gn_prod     <= gn_d * wt_s;
        r_s1_shift       <= i_head.shift;
    end

    // stage 2: floor interpolation, then apply the formant shift
    logic signed [27:0] hz_sum;
    logic signed [27:0] gn_sum;
    logic [12:0]        hz_l;

    assign hz_sum = $signed({15'd0, r_s1_hz_a}) + (r_s1_hz_prod >>> 12);
    assign gn_sum = $signed({15'd0, r_s1_gn_a}) + (r_s1_gn_prod >>> 12);
    assign hz_l   = hz_sum[12:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_tag  <= r_s1_tag;
        r_s2_hzs  <= hz_l * r_s1_shift;
        r_s2_gain <= gn_sum[12:0];
    end

    // stage 3: round and clamp the shifted frequency
    logic [26:0] hz_rnd;
    logic [14:0] hz_q;
    logic [12:0] hz_c;

    assign hz_rnd = {1'b0, r_s2_hzs} + 27'd2048;
    assign hz_q   = hz_rnd[26:12];

    always_comb begin
        priority if (hz_q < HZ_MIN) begin
            hz_c = HZ_MIN[12:0];
        end else if (hz_q > HZ_MAX) begin
            hz_c = HZ_MAX[12:0];
        end else begin
            hz_c = hz_q[12:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
        r_s3_tag  <= r_s2_tag;
        r_s3_hz   <= hz_c;
        r_s3_gain <= r_s2_gain;
    end

    // stage 4: reciprocal product in two halves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid;
        end
        r_s4_tag  <= r_s3_tag;
        r_s4_plo  <= r_s3_hz * RECIP[31:0];
        r_s4_phi  <= r_s3_hz * RECIP[63:32];
        r_s4_gain <= r_s3_gain;
    end

    // stage 5: combine halves into the phase increment
    logic [76:0] inc_full;

    assign inc_full = {r_s4_phi, 32'd0} + {32'd0, r_s4_plo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_s4_valid;
        end
        r_o_tag  <= r_s4_tag;
        r_o_inc  <= inc_full[60:31];
        r_o_gain <= r_s4_gain;
    end

    assign o_strobe            = r_o_valid;
    assign o_channel           = r_o_tag.ch;
    assign o_formant_slot      = r_o_tag.slot;
    assign o_carrier_increment = r_o_tag.carrier;
    assign o_formant_increment = r_o_inc;
    assign o_formant_amplitude = r_o_gain;
    assign o_last_result       = r_o_tag.last;

endmodule

[rtl/vowel_formant_control_frame.sv]
// Vowel formant control frame. A knob word is taken when start is high and
// busy is low; it yields six result words, channel 0 slots 0..2 then channel 1
// slots 0..2, one per clock, each shown for one cycle with o_strobe high and
// o_last_result marking the sixth. The receiver cannot stall. The first result
// passes from the frame queue through pipeline stages 1 to 4 and the output
// register to the ports. A two-entry frame queue sits behind the input, and
// the result sequencer issues one result per cycle while a frame waits, so a
// sustained stream runs at one knob word per six results; busy rises only
// when the queue holds two frames, the one being sequenced and one behind it.
module vowel_formant_control_frame
    import vfc_pkg::*;
#(
    parameter int unsigned SAMPLE_RATE_HZ = 48000
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] i_knob_x,
    input  logic [11:0] i_knob_y,
    input  logic        i_alt_mode,
    input  logic [31:0] i_pitch_increment,
    output logic        o_strobe,
    output logic        o_channel,
    output logic [1:0]  o_formant_slot,
    output logic [31:0] o_carrier_increment,
    output logic [29:0] o_formant_increment,
    output logic [12:0] o_formant_amplitude,
    output logic        o_last_result
);

    t_frame front_word;
    t_frame head_word;
    logic   q_empty;
    logic   q_full;
    logic   q_pop;
    logic   push;

    // accept a word whenever the queue has room
    assign busy = q_full;
    assign push = start && !q_full;

    // decode knobs into segment, weight and shift
    vfc_front u_front (
        .i_knob_x          (i_knob_x),
        .i_knob_y          (i_knob_y),
        .i_alt_mode        (i_alt_mode),
        .i_pitch_increment (i_pitch_increment),
        .o_frame           (front_word)
    );

    // frame queue between decode and result generation
    vfc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_word (front_word),
        .i_pop       (q_pop),
        .o_head      (head_word),
        .o_empty     (q_empty),
        .o_full      (q_full)
    );

    // result sequencer and arithmetic pipeline
    vfc_back #(
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_head              (head_word),
        .i_empty             (q_empty),
        .o_pop               (q_pop),
        .o_strobe            (o_strobe),
        .o_channel           (o_channel),
        .o_formant_slot      (o_formant_slot),
        .o_carrier_increment (o_carrier_increment),
        .o_formant_increment (o_formant_increment),
        .o_formant_amplitude (o_formant_amplitude),
        .o_last_result       (o_last_result)
    );

endmodule
